// ----- hdl/point_nms_by_area_core_macros.svh -----
// assertion macros for the point suppression core
`ifndef POINT_NMS_BY_AREA_CORE_MACROS_SVH
`define POINT_NMS_BY_AREA_CORE_MACROS_SVH

// same-cycle implication under reset
`define PNMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pnms check failed");

// next-cycle implication under reset
`define PNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnms check failed");

`endif

// ----- hdl/pnms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnms_pkg
// shared constants and types of the point suppression core
// ----------------------------------------------------------------------------
package pnms_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 12;
    localparam int AREA_W     = 24;
    localparam int THR_W      = 12;
    localparam int T2_W       = 2 * THR_W;
    localparam int D2_W       = 2 * COORD_W + 1;
    localparam logic [THR_W-1:0] THR_RESET = 12'd50;

    // one point held in a cell of the ring
    typedef struct packed {
        logic               alive;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [AREA_W-1:0]  area;
    } t_point;

    // the point kept last, against which the ring is thinned
    typedef struct packed {
        logic               ok;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_win;

endpackage
`default_nettype wire

// ----- hdl/pnms_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnms_in_if
// point beat channel into the suppression core
// ----------------------------------------------------------------------------
interface pnms_in_if;
    import pnms_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [AREA_W-1:0]  point_area;
    logic               is_final;

    modport source (output valid, point_x, point_y, point_area, is_final, input ready);
    modport sink   (input valid, point_x, point_y, point_area, is_final, output ready);
endinterface
`default_nettype wire

// ----- hdl/pnms_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnms_out_if
// kept point beat channel out of the suppression core
// ----------------------------------------------------------------------------
interface pnms_out_if;
    import pnms_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] kept_x;
    logic [COORD_W-1:0] kept_y;
    logic [AREA_W-1:0]  kept_area;
    logic               run_end;
    logic               set_empty;
    logic               overflowed;

    modport source (output valid, kept_x, kept_y, kept_area, run_end, set_empty,
                    overflowed, input ready);
    modport sink   (input valid, kept_x, kept_y, kept_area, run_end, set_empty,
                    overflowed, output ready);
endinterface
`default_nettype wire

// ----- hdl/pnms_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnms_cell
// one storage cell of the point ring, passes its point on when shifted
// ----------------------------------------------------------------------------
module pnms_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire pnms_pkg::t_point i_pt,
    output pnms_pkg::t_point     o_pt
);
    import pnms_pkg::*;

    logic               r_alive;
    logic [IDX_W-1:0]   r_idx;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [AREA_W-1:0]  r_area;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else if (i_shift) begin
            r_alive <= i_pt.alive;
        end
    end

    // point payload
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_idx  <= i_pt.idx;
            r_x    <= i_pt.x;
            r_y    <= i_pt.y;
            r_area <= i_pt.area;
        end
    end

    assign o_pt = '{alive: r_alive, idx: r_idx, x: r_x, y: r_y, area: r_area};
endmodule
`default_nettype wire

// ----- hdl/pnms_head.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnms_head
// distance test at the ring head, drops points near the last kept point
// ----------------------------------------------------------------------------
module pnms_head (
    input  wire pnms_pkg::t_point      i_pt,
    input  wire pnms_pkg::t_win        i_win,
    input  wire logic [pnms_pkg::T2_W-1:0] i_t2,
    output pnms_pkg::t_point           o_pt
);
    import pnms_pkg::*;

    logic [COORD_W-1:0] w_dx;
    logic [COORD_W-1:0] w_dy;
    logic [D2_W-1:0]    w_d2;
    logic               w_near;
    logic               w_self;

    // absolute differences
    assign w_dx = (i_win.x >= i_pt.x) ? (i_win.x - i_pt.x) : (i_pt.x - i_win.x);
    assign w_dy = (i_win.y >= i_pt.y) ? (i_win.y - i_pt.y) : (i_pt.y - i_win.y);

    // squared distance against squared radius
    assign w_d2   = (D2_W'(w_dx) * D2_W'(w_dx)) + (D2_W'(w_dy) * D2_W'(w_dy));
    assign w_near = w_d2 < D2_W'(i_t2);
    assign w_self = i_pt.idx == i_win.idx;

    always_comb begin
        o_pt       = i_pt;
        o_pt.alive = i_pt.alive && !(i_win.ok && (w_near || w_self));
    end
endmodule
`default_nettype wire

// ----- hdl/point_nms_by_area_core.sv -----
// sequence: each sweep of the ring picks the best surviving point; a kept point is offered once
// the next sweep has thinned the ring against it; an empty set closes after the first sweep.
// throughput: points load one per cycle while the core is in its load state; every sweep
// passes the whole ring through the single distance unit at the ring head.
// reset: synchronous active low; clears the ring occupancy, counters and radius (50).
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_nms_by_area_core
// greedy suppression of centroid points by area over a rotating ring of cells
// ----------------------------------------------------------------------------
module point_nms_by_area_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [pnms_pkg::THR_W-1:0] i_cfg_data,
    pnms_in_if.sink                      i_pt,
    pnms_out_if.source                   o_kept
);
    import pnms_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [IDX_W-1:0]   r_step;
    logic [THR_W-1:0]   r_thr;
    logic [T2_W-1:0]    r_t2;
    t_win               r_win;
    t_point             r_best;
    logic               r_best_ok;
    t_point             r_pend;
    logic               r_have_pend;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [AREA_W-1:0]  r_out_area;
    logic               r_out_end;
    logic               r_out_empty;
    logic               r_out_ovf;

    t_point             w_cell_q [MAX_POINTS];
    t_point             w_head_out;
    t_point             w_ring_in;
    t_point             w_new;
    logic               w_in_acc;
    logic               w_room;
    logic               w_shift;
    logic               w_out_free;
    logic               w_better;
    logic               w_emit;

    assign w_in_acc   = i_pt.valid && i_pt.ready;
    assign w_room     = r_count < CNT_W'(MAX_POINTS);
    assign w_out_free = !r_out_valid || o_kept.ready;
    assign i_pt.ready = r_state == ST_LOAD;

    // a result beat is loaded into the output register
    assign w_emit = (r_state == ST_DECIDE) && w_out_free && (r_have_pend || !r_best_ok);

    // incoming point as a ring entry
    assign w_new = '{alive: 1'b1, idx: r_count[IDX_W-1:0], x: i_pt.point_x,
                     y: i_pt.point_y, area: i_pt.point_area};

    // ring shifts on a stored beat and on every scan cycle
    assign w_shift   = (r_state == ST_SCAN) || (w_in_acc && w_room);
    assign w_ring_in = (r_state == ST_LOAD) ? w_new : w_head_out;

    // distance unit at the ring head
    pnms_head u_head (
        .i_pt  (w_cell_q[MAX_POINTS-1]),
        .i_win (r_win),
        .i_t2  (r_t2),
        .o_pt  (w_head_out)
    );

    // chain of cells
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        pnms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_pt    ((g == 0) ? w_ring_in : w_cell_q[(g == 0) ? 0 : g - 1]),
            .o_pt    (w_cell_q[g])
        );
    end

    // larger area wins, later load wins a tie
    assign w_better = w_head_out.alive && (!r_best_ok || (w_head_out.area > r_best.area) ||
                      ((w_head_out.area == r_best.area) && (w_head_out.idx > r_best.idx)));

    // radius register and its square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
        r_t2 <= T2_W'(r_thr) * T2_W'(r_thr);
    end

    // candidate tracking over a sweep
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && w_better) begin
            r_best <= w_head_out;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_step      <= '0;
            r_win       <= '0;
            r_best_ok   <= 1'b0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_kept.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_pt.is_final) begin
                            r_state     <= ST_SCAN;
                            r_step      <= '0;
                            r_win.ok    <= 1'b0;
                            r_best_ok   <= 1'b0;
                            r_have_pend <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    r_step <= r_step + IDX_W'(1);
                    if (w_better) begin
                        r_best_ok <= 1'b1;
                    end
                    if (r_step == IDX_W'(MAX_POINTS - 1)) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (w_emit) begin
                        // hand out the held result, last one when nothing is left
                        r_out_end   <= !r_best_ok;
                        r_out_empty <= !r_have_pend;
                        r_out_x     <= r_have_pend ? r_pend.x : '0;
                        r_out_y     <= r_have_pend ? r_pend.y : '0;
                        r_out_area  <= r_have_pend ? r_pend.area : '0;
                        r_out_ovf   <= r_have_pend ? r_ovf : 1'b0;
                    end
                    if (r_best_ok && (w_out_free || !r_have_pend)) begin
                        r_pend      <= r_best;
                        r_have_pend <= 1'b1;
                        r_win       <= '{ok: 1'b1, idx: r_best.idx, x: r_best.x, y: r_best.y};
                        r_best_ok   <= 1'b0;
                        r_step      <= '0;
                        r_state     <= ST_SCAN;
                    end else if (!r_best_ok && w_out_free) begin
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                        r_have_pend <= 1'b0;
                        r_win.ok    <= 1'b0;
                        r_state     <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_kept.valid      = r_out_valid;
    assign o_kept.kept_x     = r_out_x;
    assign o_kept.kept_y     = r_out_y;
    assign o_kept.kept_area  = r_out_area;
    assign o_kept.run_end    = r_out_end;
    assign o_kept.set_empty  = r_out_empty;
    assign o_kept.overflowed = r_out_ovf;
endmodule
`default_nettype wire

// ----- hdl/pnms_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "point_nms_by_area_core_macros.svh"
// ----------------------------------------------------------------------------
// pnms_checker
// port-level checks of the point suppression core
// ----------------------------------------------------------------------------
module pnms_port_checks (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_final,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [11:0] i_kept_x,
    input wire logic [23:0] i_kept_area,
    input wire logic        i_run_end,
    input wire logic        i_set_empty,
    input wire logic        i_overflowed
);
    // stalled result beat holds
    `PNMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kept_x) && $stable(i_kept_area) && $stable(i_run_end))
    // empty set result is a bare closing beat
    `PNMS_ASSERT_NOW(a_empty_form, i_clk, i_rst_n, i_out_valid && i_set_empty, i_run_end && !i_overflowed && (i_kept_area == 24'd0) && (i_kept_x == 12'd0))
    // a final point closes the input side
    `PNMS_ASSERT_NEXT(a_final_stops, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_final, !i_in_ready)
    // no new points while a set is still being reported
    `PNMS_ASSERT_NOW(a_busy_mid_set, i_clk, i_rst_n, i_out_valid && !i_run_end, !i_in_ready)
endmodule

bind point_nms_by_area_core pnms_port_checks u_pnms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pt.valid),
    .i_in_ready   (i_pt.ready),
    .i_in_final   (i_pt.is_final),
    .i_out_valid  (o_kept.valid),
    .i_out_ready  (o_kept.ready),
    .i_kept_x     (o_kept.kept_x),
    .i_kept_area  (o_kept.kept_area),
    .i_run_end    (o_kept.run_end),
    .i_set_empty  (o_kept.set_empty),
    .i_overflowed (o_kept.overflowed)
);
`default_nettype wire
